FILE: sv/assert_macros.svh
// assertion macros shared by the digit writer rtl
// no dependencies; each file that asserts includes this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/sdw_pkg.sv
// shared types, constants and microcode program of the digit writer
// no dependencies
package sdw_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int BLANK_ADDRS = 8;
  localparam int USABLE_INT  = (DIGIT_COUNT < 1) ? 1 :
                               ((DIGIT_COUNT > BLANK_ADDRS) ? BLANK_ADDRS : DIGIT_COUNT);

  localparam logic [3:0] USABLE_DIGITS  = 4'(USABLE_INT);
  localparam logic [3:0] LAST_BLANK_POS = 4'(BLANK_ADDRS - 1);

  localparam logic [3:0] CODE_BLANK = 4'hF;
  localparam logic [3:0] CODE_MINUS = 4'hA;

  // ceil(2^35 / 10): q = (m * RECIP_TEN) >> 35 is exact for every 32-bit m
  localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef logic [2:0] step_t;

  // digit sits right before sign so a zero quotient falls through to it
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_BLANK = 3'd1;
  localparam step_t STEP_PREP  = 3'd2;
  localparam step_t STEP_MUL   = 3'd3;
  localparam step_t STEP_DIGIT = 3'd4;
  localparam step_t STEP_SIGN  = 3'd5;
  localparam step_t STEP_DONE  = 3'd6;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NOT_START,
    COND_BLANK_MORE,
    COND_QUOT_NZ
  } cond_t;

  typedef struct packed {
    logic  idle;
    logic  op_blank;
    logic  op_clrpos;
    logic  op_mul;
    logic  op_digit;
    logic  op_sign;
    logic  op_done;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic blank_more;
    logic quot_nz;
  } dp_flags_t;

  // microcode rom: taken jump goes to target, otherwise to the next step
  function automatic ctrl_word_t ucode_word(input step_t step);
    ctrl_word_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.idle   = 1'b1;
        w.cond   = COND_NOT_START;
        w.target = STEP_IDLE;
      end
      STEP_BLANK: begin
        w.op_blank = 1'b1;
        w.cond     = COND_BLANK_MORE;
        w.target   = STEP_BLANK;
      end
      STEP_PREP: begin
        w.op_clrpos = 1'b1;
        w.op_mul    = 1'b1;
        w.cond      = COND_ALWAYS;
        w.target    = STEP_DIGIT;
      end
      STEP_DIGIT: begin
        w.op_digit = 1'b1;
        w.cond     = COND_QUOT_NZ;
        w.target   = STEP_MUL;
      end
      STEP_MUL: begin
        w.op_mul = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_DIGIT;
      end
      STEP_SIGN: begin
        w.op_sign = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_DONE;
      end
      STEP_DONE: begin
        w.op_done = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/signed_decimal_digit_writer_core.sv
// top level of the signed decimal digit writer for a code-b led display driver
// depends on sdw_pkg, sdw_sequencer and sdw_datapath (which include assert_macros.svh)
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  input    | start & !busy             | in_value (signed 32)
//  result   | out_strobe, one cycle     | out_digit_addr, out_digit_code, out_last,
//           |                           | out_overflow
//
// one beat in gives 9 to 16 result beats: eight blanks, the digits, then a minus
// sign for a negative value if a position is left; the digit loop runs once per
// decimal digit of the magnitude (1..10) and spends two microcode steps per digit
// (multiply by the reciprocal of ten, then split off quotient and digit)
// last result beat is on the ports in the first cycle with busy low; a new beat may be
// taken that cycle
// rst_n is synchronous; reset returns the sequencer to its idle step and drops results
// the receiver cannot stall, so result beats are never held
module signed_decimal_digit_writer_core
  import sdw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic signed [31:0] in_value,
  output logic              out_strobe,
  output logic [3:0]        out_digit_addr,
  output logic [3:0]        out_digit_code,
  output logic              out_last,
  output logic              out_overflow
);

  // control word of the current microcode step
  ctrl_word_t cw;
  // branch conditions back from the datapath
  dp_flags_t  flags;

  // step counter and rom
  sdw_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .cw    (cw),
    .busy  (busy)
  );

  // magnitude, divider by ten, write position and output staging
  sdw_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_value       (in_value),
    .cw             (cw),
    .flags          (flags),
    .out_strobe     (out_strobe),
    .out_digit_addr (out_digit_addr),
    .out_digit_code (out_digit_code),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

endmodule

FILE: sv/sdw_sequencer.sv
// step counter, microcode rom lookup and conditional jumps
// depends on sdw_pkg and assert_macros.svh
`include "assert_macros.svh"

module sdw_sequencer
  import sdw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_flags_t  flags,
  output ctrl_word_t cw,
  output logic       busy
);

  step_t step_r, step_nxt;
  logic  taken;

  assign cw   = ucode_word(step_r);
  assign busy = ~cw.idle;

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:     taken = 1'b1;
      COND_NOT_START:  taken = ~start;
      COND_BLANK_MORE: taken = flags.blank_more;
      COND_QUOT_NZ:    taken = flags.quot_nz;
      default:         taken = 1'b1;
    endcase
    step_nxt = taken ? cw.target : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPL(a_idle_only_at_step0, clk, rst_n, !busy, step_r == STEP_IDLE)

endmodule

FILE: sv/sdw_datapath.sv
// magnitude register, reciprocal divide by ten, write position and result staging
// depends on sdw_pkg and assert_macros.svh
`include "assert_macros.svh"

module sdw_datapath
  import sdw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic signed [31:0] in_value,
  input  ctrl_word_t        cw,
  output dp_flags_t         flags,
  output logic              out_strobe,
  output logic [3:0]        out_digit_addr,
  output logic [3:0]        out_digit_code,
  output logic              out_last,
  output logic              out_overflow
);

  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        drop_r, drop_nxt;
  logic [63:0] prod_r;

  logic        pend_valid_r, pend_valid_nxt;
  logic [3:0]  pend_addr_r, pend_addr_nxt;
  logic [3:0]  pend_code_r, pend_code_nxt;

  logic        ostb_r, ostb_nxt;
  logic [3:0]  oaddr_r, oaddr_nxt;
  logic [3:0]  ocode_r, ocode_nxt;
  logic        olast_r, olast_nxt;
  logic        oovf_r, oovf_nxt;

  logic [31:0] quot;
  logic [31:0] digit_full;
  logic [3:0]  digit;
  logic        room;
  logic        emit_en;
  logic [3:0]  emit_code;
  logic        load;
  logic [31:0] in_bits;

  assign in_bits    = in_value;
  assign quot       = 32'(prod_r >> RECIP_SHIFT);
  assign digit_full = mag_r - ((quot << 3) + (quot << 1));
  assign digit      = digit_full[3:0];
  assign room       = pos_r < USABLE_DIGITS;
  assign load       = cw.idle && start;

  assign flags.blank_more = pos_r != LAST_BLANK_POS;
  assign flags.quot_nz    = quot != 32'd0;

  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    drop_nxt  = drop_r;
    emit_en   = 1'b0;
    emit_code = CODE_BLANK;

    if (load) begin
      neg_nxt  = in_bits[31];
      mag_nxt  = in_bits[31] ? (32'd0 - in_bits) : in_bits;
      pos_nxt  = 4'd0;
      drop_nxt = 1'b0;
    end
    if (cw.op_blank) begin
      emit_en   = 1'b1;
      emit_code = CODE_BLANK;
      pos_nxt   = pos_r + 4'd1;
    end
    if (cw.op_clrpos) begin
      pos_nxt = 4'd0;
    end
    if (cw.op_digit) begin
      mag_nxt = quot;
      if (room) begin
        emit_en   = 1'b1;
        emit_code = digit;
        pos_nxt   = pos_r + 4'd1;
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cw.op_sign && neg_r) begin
      if (room) begin
        emit_en   = 1'b1;
        emit_code = CODE_MINUS;
        pos_nxt   = pos_r + 4'd1;
      end else begin
        drop_nxt = 1'b1;
      end
    end

    // one write is held back so the final one can carry last and overflow
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_code_nxt  = pend_code_r;
    ostb_nxt       = 1'b0;
    oaddr_nxt      = pend_addr_r;
    ocode_nxt      = pend_code_r;
    olast_nxt      = 1'b0;
    oovf_nxt       = 1'b0;
    if (emit_en) begin
      ostb_nxt       = pend_valid_r;
      pend_valid_nxt = 1'b1;
      pend_addr_nxt  = pos_r + 4'd1;
      pend_code_nxt  = emit_code;
    end else if (cw.op_done) begin
      ostb_nxt       = pend_valid_r;
      olast_nxt      = 1'b1;
      oovf_nxt       = drop_r;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r        <= 32'd0;
      neg_r        <= 1'b0;
      pos_r        <= 4'd0;
      drop_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      ostb_r       <= 1'b0;
    end else begin
      mag_r        <= mag_nxt;
      neg_r        <= neg_nxt;
      pos_r        <= pos_nxt;
      drop_r       <= drop_nxt;
      pend_valid_r <= pend_valid_nxt;
      ostb_r       <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op_mul) begin
      prod_r <= 64'(mag_r) * 64'(RECIP_TEN);
    end
    pend_addr_r <= pend_addr_nxt;
    pend_code_r <= pend_code_nxt;
    oaddr_r     <= oaddr_nxt;
    ocode_r     <= ocode_nxt;
    olast_r     <= olast_nxt;
    oovf_r      <= oovf_nxt;
  end

  assign out_strobe     = ostb_r;
  assign out_digit_addr = oaddr_r;
  assign out_digit_code = ocode_r;
  assign out_last       = olast_r;
  assign out_overflow   = oovf_r;

  `ASSERT_IMPL(a_addr_in_range, clk, rst_n, ostb_r, oaddr_r >= 4'd1 && oaddr_r <= 4'd8)
  `ASSERT_IMPL(a_ovf_only_last, clk, rst_n, ostb_r && oovf_r, olast_r)
  `ASSERT_NEXT(a_gap_after_last, clk, rst_n, ostb_r && olast_r, !ostb_r)
  `ASSERT_IMPL(a_pos_bounded, clk, rst_n, cw.op_sign || cw.op_digit, pos_r <= USABLE_DIGITS)

endmodule
